// File: hdl/mf3_pkg.sv
`default_nettype none

package mf3_pkg;

  // Channels per pixel and the width of one channel byte
  localparam int unsigned NUM_CH = 4;
  localparam int unsigned CH_W   = 8;

  // Width of the image dimension registers and their smallest legal value
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned DIM_MIN = 3;
  localparam int unsigned MASK_W  = 4;

  // Register map, index = paddr[3:2]
  localparam int unsigned ADDR_W = 4;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MASK   = 2'd2;

  // Register reset values
  localparam int unsigned WIDTH_RST  = 640;
  localparam int unsigned HEIGHT_RST = 480;
  localparam logic [MASK_W-1:0] MASK_RST = 4'b0111;

  typedef logic [NUM_CH*CH_W-1:0] pixel_t;

  // 3x3 window: entry col*3 + row, column 0 oldest, row 0 oldest line
  typedef pixel_t [8:0] window_t;

  // Border flags of the pixel whose result is being formed
  typedef struct packed {
    logic first_col;
    logic last_col;
    logic first_row;
    logic last_row;
  } border_t;

  // Saturate a written dimension into [DIM_MIN, hi]
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [31:0] hi);
    logic [DIM_W-1:0] r;
    if (32'(v) < 32'(DIM_MIN)) begin
      r = DIM_W'(DIM_MIN);
    end else if (32'(v) > hi) begin
      r = hi[DIM_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mf3_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module mf3_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/mf3_window_median.sv
`default_nettype none

// Per-channel 3x3 median with border replication and channel mask
module mf3_window_median import mf3_pkg::*; (
  input  wire window_t           win_i,
  input  wire border_t           bord_i,
  input  wire logic [MASK_W-1:0] mask_i,
  output pixel_t                 pix_o
);

  // compare-exchange: returns {min, max}
  function automatic logic [2*CH_W-1:0] cx(input logic [CH_W-1:0] x,
                                           input logic [CH_W-1:0] y);
    return (x > y) ? {y, x} : {x, y};
  endfunction

  // 19-step median network
  function automatic logic [CH_W-1:0] median9(input logic [8:0][CH_W-1:0] vi);
    logic [8:0][CH_W-1:0] v;
    v = vi;
    {v[1], v[2]} = cx(v[1], v[2]);
    {v[4], v[5]} = cx(v[4], v[5]);
    {v[7], v[8]} = cx(v[7], v[8]);
    {v[0], v[1]} = cx(v[0], v[1]);
    {v[3], v[4]} = cx(v[3], v[4]);
    {v[6], v[7]} = cx(v[6], v[7]);
    {v[1], v[2]} = cx(v[1], v[2]);
    {v[4], v[5]} = cx(v[4], v[5]);
    {v[7], v[8]} = cx(v[7], v[8]);
    {v[0], v[3]} = cx(v[0], v[3]);
    {v[5], v[8]} = cx(v[5], v[8]);
    {v[4], v[7]} = cx(v[4], v[7]);
    {v[3], v[6]} = cx(v[3], v[6]);
    {v[1], v[4]} = cx(v[1], v[4]);
    {v[2], v[5]} = cx(v[2], v[5]);
    {v[4], v[7]} = cx(v[4], v[7]);
    {v[4], v[2]} = cx(v[4], v[2]);
    {v[6], v[4]} = cx(v[6], v[4]);
    {v[4], v[2]} = cx(v[4], v[2]);
    return v[4];
  endfunction

  logic [2:0][3:0] col_base;
  logic [2:0][3:0] row_off;
  window_t         nbr;
  pixel_t          centre;

  // Border replication: out-of-image neighbors take the centre column/row
  always_comb begin
    col_base[0] = bord_i.first_col ? 4'd3 : 4'd0;
    col_base[1] = 4'd3;
    col_base[2] = bord_i.last_col ? 4'd3 : 4'd6;
    row_off[0]  = bord_i.first_row ? 4'd1 : 4'd0;
    row_off[1]  = 4'd1;
    row_off[2]  = bord_i.last_row ? 4'd1 : 4'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        nbr[i*3+j] = win_i[col_base[j] + row_off[i]];
      end
    end
    centre = win_i[4];
  end

  // Median or pass-through per channel
  always_comb begin
    logic [8:0][CH_W-1:0] v;
    for (int k = 0; k < NUM_CH; k++) begin
      for (int n = 0; n < 9; n++) begin
        v[n] = nbr[n][k*CH_W +: CH_W];
      end
      pix_o[k*CH_W +: CH_W] = mask_i[k] ? median9(v) : centre[k*CH_W +: CH_W];
    end
  end

endmodule

`default_nettype wire

// File: hdl/median_3x3_pixel_filter.sv
// 3x3 median filter for four-channel 8-bit pixels in raster order.
// Input channel: in_valid_i / in_stall_o with req_type_i and in_ch0_i..in_ch3_i.
//   req_type_i = 0 carries a pixel; 1 is a flush request that pushes an empty
//   slot so the last line can drain (ignored when no pixel is pending).
// Output channel: out_valid_o / out_stall_i with out_ch0_o..out_ch3_o and the
//   end-of-line / end-of-frame flags of the pixel the result belongs to.
// The result for a pixel comes out image_width + 1 requests after the pixel;
// the first image_width + 1 requests of a stream give no result.
// Pipeline: an accepted request waits in stage 1; one giving a result then
//   enters the output register. One request is taken every cycle unless the
//   input stalls; each line store reads at accept and writes from stage 1.
// A stalled result waits in the output register while the next request is
//   already held in the stage before it; the input stalls only when both are
//   occupied and the receiver is stalling.
// APB registers: 0x0 image_width, 0x4 image_height (both saturated into
//   [3, MAX], a write restarts the stream), 0x8 channel_mask.
// Reset: 640 x 480, mask 0111, empty stream, window cleared. The line stores
//   are not cleared; their unwritten entries only feed replicated borders.
`default_nettype none

module median_3x3_pixel_filter import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              req_type_i,
  input  wire logic [CH_W-1:0]   in_ch0_i,
  input  wire logic [CH_W-1:0]   in_ch1_i,
  input  wire logic [CH_W-1:0]   in_ch2_i,
  input  wire logic [CH_W-1:0]   in_ch3_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [CH_W-1:0]   out_ch0_o,
  output logic      [CH_W-1:0]   out_ch1_o,
  output logic      [CH_W-1:0]   out_ch2_o,
  output logic      [CH_W-1:0]   out_ch3_o,
  output logic                   out_end_of_line_o,
  output logic                   out_end_of_frame_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned PW = DIM_W + 1;
  localparam int unsigned SW = DIM_W + 2;
  localparam logic [DIM_W-1:0] W_RST =
    DIM_W'((MAX_WIDTH < WIDTH_RST) ? MAX_WIDTH : WIDTH_RST);
  localparam logic [DIM_W-1:0] H_RST =
    DIM_W'((MAX_HEIGHT < HEIGHT_RST) ? MAX_HEIGHT : HEIGHT_RST);

  // configuration and stream position
  logic [DIM_W-1:0]  width_q, height_q;
  logic [MASK_W-1:0] mask_q;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [PW-1:0]     pend_q, pend_d;
  logic [PW-1:0]     drain_q, drain_d;

  // stage 1: accepted request waiting for line store data
  logic              s1_v_q;
  logic              s1_res_q;
  pixel_t            s1_pix_q;
  logic [CW-1:0]     s1_wc_q;
  border_t           s1_bord_q;
  logic              s1_adv;

  // window and output register
  window_t           win_q, win_d;
  pixel_t            med_pix;
  logic              out_v_q;
  pixel_t            out_pix_q;
  logic              out_eol_q, out_eof_q;

  // accept-side signals
  logic              cfg_wr;
  logic              take, act, flush, restart_pix;
  logic [CW-1:0]     c;
  logic [RW-1:0]     r;
  logic [PW-1:0]     p, d;
  logic [SW-1:0]     wsum;
  logic [CW-1:0]     wc;
  logic              full;
  border_t           bord;
  pixel_t            in_pix;
  pixel_t            old_rdata, new_rdata;
  logic [PW-1:0]     p_after;

  // APB access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      REG_MASK:   prdata = 32'(mask_q);
      default:    prdata = '0;
    endcase
  end

  // Handshake
  assign s1_adv     = s1_v_q & (~s1_res_q | ~out_v_q | ~out_stall_i);
  assign in_stall_o = s1_v_q & ~s1_adv;
  assign take       = in_valid_i & ~in_stall_o;
  assign flush      = req_type_i;
  assign act        = take & ~(flush & (pend_q == '0));
  assign in_pix     = flush ? '0 : {in_ch3_i, in_ch2_i, in_ch1_i, in_ch0_i};

  // Position after a pending drain is dropped by a new pixel
  assign restart_pix = ~flush & (drain_q != '0);
  assign c = restart_pix ? '0 : col_q;
  assign r = restart_pix ? '0 : row_q;
  assign p = restart_pix ? '0 : pend_q;
  assign d = restart_pix ? '0 : drain_q;

  // Line store column: (col + pending + drain) mod width
  always_comb begin
    wsum = SW'(c) + SW'(p) + SW'(d);
    if (wsum >= SW'(width_q)) wsum = wsum - SW'(width_q);
    if (wsum >= SW'(width_q)) wsum = wsum - SW'(width_q);
    wc   = wsum[CW-1:0];
    full = (SW'(p) + SW'(d)) == (SW'(width_q) + SW'(1));
    bord.first_col = (c == '0);
    bord.last_col  = (SW'(c) == (SW'(width_q) - SW'(1)));
    bord.first_row = (r == '0);
    bord.last_row  = (SW'(r) == (SW'(height_q) - SW'(1)));
  end

  // Next stream position for an active request
  always_comb begin
    col_d   = c;
    row_d   = r;
    pend_d  = p;
    drain_d = d;
    p_after = flush ? p - PW'(1) : p;
    if (!full) begin
      if (flush) drain_d = d + PW'(1);
      else       pend_d  = p + PW'(1);
    end else begin
      if (bord.last_col) begin
        col_d = '0;
        row_d = bord.last_row ? '0 : r + RW'(1);
      end else begin
        col_d = c + CW'(1);
      end
      pend_d = p_after;
      if (flush) drain_d = d + PW'(1);
      if (p_after == '0) begin
        col_d   = '0;
        row_d   = '0;
        pend_d  = '0;
        drain_d = '0;
      end
    end
  end

  // Config registers and stream counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= W_RST;
      height_q <= H_RST;
      mask_q   <= MASK_RST;
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
      drain_q  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH: begin
          width_q <= clamp_dim(pwdata[DIM_W-1:0], 32'(MAX_WIDTH));
          col_q   <= '0;
          row_q   <= '0;
          pend_q  <= '0;
          drain_q <= '0;
        end
        REG_HEIGHT: begin
          height_q <= clamp_dim(pwdata[DIM_W-1:0], 32'(MAX_HEIGHT));
          col_q    <= '0;
          row_q    <= '0;
          pend_q   <= '0;
          drain_q  <= '0;
        end
        REG_MASK: begin
          mask_q <= pwdata[MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (act) begin
      col_q   <= col_d;
      row_q   <= row_d;
      pend_q  <= pend_d;
      drain_q <= drain_d;
    end
  end

  // Stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (act) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act) begin
      s1_res_q  <= full;
      s1_pix_q  <= in_pix;
      s1_wc_q   <= wc;
      s1_bord_q <= bord;
    end
  end

  // Line stores: read at accept, older <= newer and newer <= pixel as stage 1 advances
  mf3_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (MAX_WIDTH)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_wc_q),
    .wdata_i (new_rdata),
    .re_i    (act),
    .raddr_i (wc),
    .rdata_o (old_rdata)
  );

  mf3_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (MAX_WIDTH)
  ) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_wc_q),
    .wdata_i (s1_pix_q),
    .re_i    (act),
    .raddr_i (wc),
    .rdata_o (new_rdata)
  );

  // Window shift by one column
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      win_d[i] = win_q[i+3];
    end
    win_d[6] = old_rdata;
    win_d[7] = new_rdata;
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_adv) begin
      win_q <= win_d;
    end
  end

  mf3_window_median u_median (
    .win_i  (win_d),
    .bord_i (s1_bord_q),
    .mask_i (mask_q),
    .pix_o  (med_pix)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv && s1_res_q) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_res_q) begin
      out_pix_q <= med_pix;
      out_eol_q <= s1_bord_q.last_col;
      out_eof_q <= s1_bord_q.last_col & s1_bord_q.last_row;
    end
  end

  assign out_valid_o        = out_v_q;
  assign out_ch0_o          = out_pix_q[0*CH_W +: CH_W];
  assign out_ch1_o          = out_pix_q[1*CH_W +: CH_W];
  assign out_ch2_o          = out_pix_q[2*CH_W +: CH_W];
  assign out_ch3_o          = out_pix_q[3*CH_W +: CH_W];
  assign out_end_of_line_o  = out_eol_q;
  assign out_end_of_frame_o = out_eof_q;

  // Assertions
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(pend_q) + SW'(drain_q)) <= (SW'(width_q) + SW'(1)))
    else $error("pending plus drain slots exceed width + 1");

  a_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(col_q) < SW'(width_q)) && (SW'(row_q) < SW'(height_q)))
    else $error("stream position outside the frame");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_q != '0) |-> (pend_q != '0))
    else $error("drain slots left with no pixel pending");

  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_res_q))
    else $error("input stalled while the output side can move");

endmodule

`default_nettype wire

// File: verif/mf3_checker.sv
`timescale 1ns / 100ps

// Watches both request channels and the register port of the median filter,
// keeps its own copy of the filter state and compares every output request
// against the oldest predicted one.
module mf3_checker import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter logic        FLUSH_CODE = 1'b1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  // input channel
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [CH_W-1:0]   in_ch0_i,
  input  logic [CH_W-1:0]   in_ch1_i,
  input  logic [CH_W-1:0]   in_ch2_i,
  input  logic [CH_W-1:0]   in_ch3_i,
  // output channel
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [CH_W-1:0]   out_ch0_o,
  input  logic [CH_W-1:0]   out_ch1_o,
  input  logic [CH_W-1:0]   out_ch2_o,
  input  logic [CH_W-1:0]   out_ch3_o,
  input  logic              out_end_of_line_o,
  input  logic              out_end_of_frame_o,
  // status for the stimulus side
  output int unsigned       fail_count_o,
  output int unsigned       owed_count_o,
  output int unsigned       pending_count_o,
  output int unsigned       checked_count_o
);

  localparam int unsigned MAX_PRINTS = 100;

  // Compare-exchange pairs of the 9-input median network, one byte {i, j}
  // per step, first step in the top byte
  localparam logic [19*8-1:0] SORT_NET = {
    8'h12, 8'h45, 8'h78, 8'h01, 8'h34, 8'h67, 8'h12, 8'h45, 8'h78, 8'h03,
    8'h58, 8'h47, 8'h36, 8'h14, 8'h25, 8'h47, 8'h42, 8'h64, 8'h42
  };

  typedef struct packed {
    logic [NUM_CH-1:0][CH_W-1:0] ch;
    logic                        eol;
    logic                        eof;
  } filt_result_t;

  // predicted filter state
  pixel_t            older_line [MAX_WIDTH];
  pixel_t            newer_line [MAX_WIDTH];
  pixel_t            win [9];
  int unsigned       col_pos;
  int unsigned       row_pos;
  int unsigned       pending;
  int unsigned       drained;
  int unsigned       line_len;
  int unsigned       frame_lines;
  logic [MASK_W-1:0] med_mask;

  filt_result_t      owed_results [$];
  int unsigned       fails;
  int unsigned       checked;
  int unsigned       prints;
  bit                produced;
  filt_result_t      predicted;

  function automatic int unsigned clamp_extent(input logic [31:0] data,
                                               input int unsigned hi);
    int unsigned v;
    v = int'(data[DIM_W-1:0]);
    if (v < DIM_MIN) v = DIM_MIN;
    else if (v > hi) v = hi;
    return v;
  endfunction

  function automatic logic [CH_W-1:0] median_of_nine(input logic [8:0][CH_W-1:0] v_in);
    logic [8:0][CH_W-1:0] v;
    logic [CH_W-1:0]      t;
    int unsigned          i;
    int unsigned          j;
    int                   s;
    v = v_in;
    for (s = 0; s < 19; s++) begin
      i = SORT_NET[8*(18-s)+4 +: 4];
      j = SORT_NET[8*(18-s) +: 4];
      if (v[i] > v[j]) begin
        t    = v[i];
        v[i] = v[j];
        v[j] = t;
      end
    end
    return v[4];
  endfunction

  task automatic restart_stream();
    col_pos = 0;
    row_pos = 0;
    pending = 0;
    drained = 0;
  endtask

  task automatic init_model();
    int i;
    for (i = 0; i < MAX_WIDTH; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    for (i = 0; i < 9; i++) win[i] = '0;
    line_len    = WIDTH_RST;
    frame_lines = HEIGHT_RST;
    med_mask    = MASK_RST;
    restart_stream();
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      REG_WIDTH: begin
        line_len = clamp_extent(data, MAX_WIDTH);
        restart_stream();
      end
      REG_HEIGHT: begin
        frame_lines = clamp_extent(data, MAX_HEIGHT);
        restart_stream();
      end
      REG_MASK: begin
        med_mask = data[MASK_W-1:0];
      end
      default: ;
    endcase
  endtask

  // Advance the state by one accepted input request; a result comes once
  // the delay line holds line_len + 1 slots
  task automatic predict_request(input logic flush, input pixel_t px_in,
                                 output bit got_one, output filt_result_t res);
    pixel_t               px;
    pixel_t               old_a;
    pixel_t               old_b;
    int unsigned          wc;
    int unsigned          cs [3];
    int unsigned          rs [3];
    logic [8:0][CH_W-1:0] nb;
    bit                   full;
    bit                   active;
    int                   i;
    int                   j;
    int                   k;
    got_one = 1'b0;
    res     = '0;
    px      = '0;
    active  = 1'b1;
    if (flush) begin
      // flush with nothing pending is a no-op
      if (pending == 0) active = 1'b0;
    end else begin
      // a pixel during a drain drops the drain and starts a new frame
      if (drained != 0) restart_stream();
      px = px_in;
    end
    if (active) begin
      full = (pending + drained) == (line_len + 1);
      wc = col_pos + pending + drained;
      if (wc >= line_len) wc -= line_len;
      if (wc >= line_len) wc -= line_len;
      if (wc >= MAX_WIDTH) wc = 0;

      // line stores and window shift
      old_a = older_line[wc];
      old_b = newer_line[wc];
      older_line[wc] = old_b;
      newer_line[wc] = px;
      for (i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = old_a;
      win[7] = old_b;
      win[8] = px;

      if (!full) begin
        if (flush) drained++;
        else pending++;
      end else begin
        // border replication picks the centre column / row at the edges
        cs[0] = (col_pos == 0) ? 1 : 0;
        cs[1] = 1;
        cs[2] = (col_pos == line_len - 1) ? 1 : 2;
        rs[0] = (row_pos == 0) ? 1 : 0;
        rs[1] = 1;
        rs[2] = (row_pos == frame_lines - 1) ? 1 : 2;
        for (k = 0; k < NUM_CH; k++) begin
          for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
              nb[i*3+j] = win[cs[j]*3 + rs[i]][CH_W*k +: CH_W];
          res.ch[k] = med_mask[k] ? median_of_nine(nb) : win[4][CH_W*k +: CH_W];
        end
        res.eol = (col_pos == line_len - 1);
        res.eof = (col_pos == line_len - 1) && (row_pos == frame_lines - 1);
        got_one = 1'b1;

        col_pos++;
        if (col_pos >= line_len) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= frame_lines) row_pos = 0;
        end
        pending--;
        if (flush) drained++;
        else pending++;
        if (pending == 0) restart_stream();
      end
    end
  endtask

  task automatic report(input string msg);
    fails++;
    if (prints < MAX_PRINTS) begin
      prints++;
      $display("%0t ns: %s", $time, msg);
      if (prints == MAX_PRINTS) $display("further mismatches are counted, not shown");
    end
  endtask

  task automatic compare_field(input string name, input logic [CH_W-1:0] want,
                               input logic [CH_W-1:0] got);
    if (want !== got)
      report($sformatf("%s expected %0h, actual %0h", name, want, got));
  endtask

  task automatic check_result();
    filt_result_t want;
    filt_result_t got;
    int           k;
    got.ch  = {out_ch3_o, out_ch2_o, out_ch1_o, out_ch0_o};
    got.eol = out_end_of_line_o;
    got.eof = out_end_of_frame_o;
    if (owed_results.size() == 0) begin
      report($sformatf("result %h with nothing expected, expected none", got));
    end else begin
      want = owed_results.pop_front();
      checked++;
      for (k = 0; k < NUM_CH; k++)
        compare_field($sformatf("out_ch%0d", k), want.ch[k], got.ch[k]);
      compare_field("out_end_of_line", want.eol, got.eol);
      compare_field("out_end_of_frame", want.eof, got.eof);
    end
  endtask

  // Output side is handled first: it answers a request taken at an earlier edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_model();
      owed_results.delete();
      fails   = 0;
      checked = 0;
      prints  = 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_result();
      if (psel && penable && pwrite && pready) write_register(paddr[3:2], pwdata);
      if (in_valid_i && !in_stall_o) begin
        predict_request(req_type_i == FLUSH_CODE,
                        {in_ch3_i, in_ch2_i, in_ch1_i, in_ch0_i}, produced, predicted);
        if (produced) owed_results.push_back(predicted);
      end
    end
    fail_count_o    = fails;
    owed_count_o    = owed_results.size();
    pending_count_o = pending;
    checked_count_o = checked;
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import mf3_pkg::*;

  localparam int unsigned MAX_WIDTH      = 4096;
  localparam int unsigned MAX_HEIGHT     = 4096;
  localparam logic        REQ_PIXEL      = 1'b0;
  localparam logic        REQ_FLUSH      = 1'b1;
  localparam logic [1:0]  REG_UNUSED     = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 8;

  // border-heavy pixels for the directed 3x3 frame
  localparam logic [9*32-1:0] CORNER_PIXELS = {
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
    32'hFFFF_FFFF, 32'h8080_8080, 32'h01FE_7F80,
    32'hFF00_FF00, 32'h00FF_00FF, 32'h7E81_7E81
  };

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_pattern_e;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic              req_type;
  logic [CH_W-1:0]   in_ch0;
  logic [CH_W-1:0]   in_ch1;
  logic [CH_W-1:0]   in_ch2;
  logic [CH_W-1:0]   in_ch3;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CH_W-1:0]   out_ch0;
  logic [CH_W-1:0]   out_ch1;
  logic [CH_W-1:0]   out_ch2;
  logic [CH_W-1:0]   out_ch3;
  logic              out_eol;
  logic              out_eof;

  int unsigned       fail_count;
  int unsigned       owed_count;
  int unsigned       pending_count;
  int unsigned       checked_count;

  int unsigned       burst_left;
  int unsigned       idle_cycles;
  int unsigned       n_pixels;
  int unsigned       n_flushes;
  int unsigned       n_settings;
  stall_pattern_e    stall_mode;
  int unsigned       stall_left;
  int unsigned       stall_tick;

  median_3x3_pixel_filter #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .req_type_i        (req_type),
    .in_ch0_i          (in_ch0),
    .in_ch1_i          (in_ch1),
    .in_ch2_i          (in_ch2),
    .in_ch3_i          (in_ch3),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_ch0_o         (out_ch0),
    .out_ch1_o         (out_ch1),
    .out_ch2_o         (out_ch2),
    .out_ch3_o         (out_ch3),
    .out_end_of_line_o (out_eol),
    .out_end_of_frame_o(out_eof)
  );

  mf3_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FLUSH_CODE(REQ_FLUSH)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .req_type_i        (req_type),
    .in_ch0_i          (in_ch0),
    .in_ch1_i          (in_ch1),
    .in_ch2_i          (in_ch2),
    .in_ch3_i          (in_ch3),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_ch0_o         (out_ch0),
    .out_ch1_o         (out_ch1),
    .out_ch2_o         (out_ch2),
    .out_ch3_o         (out_ch3),
    .out_end_of_line_o (out_eol),
    .out_end_of_frame_o(out_eof),
    .fail_count_o      (fail_count),
    .owed_count_o      (owed_count),
    .pending_count_o   (pending_count),
    .checked_count_o   (checked_count)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Receiver stall: the pattern is drawn anew at random whenever its run ends
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_pattern_e'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= ((stall_tick % 5) < 2);
    endcase
  end

  // Watchdog: too long without any request moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic pixel_t rand_pixel();
    pixel_t      p;
    int unsigned k;
    p = $urandom;
    // bias some bytes to the extremes so medians see ties
    for (k = 0; k < NUM_CH; k++) begin
      case ($urandom_range(0, 7))
        0:       p[CH_W*k +: CH_W] = '0;
        1:       p[CH_W*k +: CH_W] = '1;
        2:       p[CH_W*k +: CH_W] = 8'h80;
        default: ;
      endcase
    end
    return p;
  endfunction

  // All stimulus tasks start and end on a falling edge
  task automatic send_request(input logic kind, input pixel_t px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    req_type <= kind;
    {in_ch3, in_ch2, in_ch1, in_ch0} <= px;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    if (kind == REQ_FLUSH) n_flushes++;
    else n_pixels++;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // hold off until every predicted result has been taken
  task automatic hold_for_results();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (owed_count != 0);
  endtask

  task automatic settle();
    hold_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // flush until the last pending pixel is answered
  task automatic drain_stream();
    while (pending_count != 0) send_request(REQ_FLUSH, $urandom);
  endtask

  task automatic run_phase(input logic [31:0] w_word, input logic [31:0] h_word,
                           input logic [31:0] m_word, input int n_req,
                           input int unsigned noise_pct, input int pause_at);
    int i;
    int unsigned k;
    settle();
    apb_write(REG_WIDTH, w_word);
    apb_write(REG_HEIGHT, h_word);
    apb_write(REG_MASK, m_word);
    n_settings++;
    for (i = 0; i < n_req; i++) begin
      if (i == pause_at) hold_for_results();
      if ($urandom_range(0, 99) < noise_pct) begin
        // stray flushes: zero neighbors mid-frame, or a drain cut short
        k = $urandom_range(1, 3);
        repeat (k) send_request(REQ_FLUSH, $urandom);
      end else begin
        send_request(REQ_PIXEL, rand_pixel());
      end
    end
    drain_stream();
  endtask

  initial begin
    int i;
    rst_ni   = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    req_type = REQ_PIXEL;
    in_ch0   = '0;
    in_ch1   = '0;
    in_ch2   = '0;
    in_ch3   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: one 3x3 frame with all channels filtered
    apb_write(REG_UNUSED, $urandom);
    apb_write(REG_WIDTH, 32'h1FFF);
    apb_write(REG_WIDTH, 32'd3);
    apb_write(REG_HEIGHT, 32'd3);
    apb_write(REG_MASK, 32'hF);
    n_settings++;
    send_request(REQ_FLUSH, '0);
    for (i = 0; i < 9; i++) send_request(REQ_PIXEL, CORNER_PIXELS[32*(8-i) +: 32]);
    drain_stream();
    // drain dropped by a new pixel, then a frame of one pixel
    for (i = 0; i < 4; i++) send_request(REQ_PIXEL, rand_pixel());
    send_request(REQ_FLUSH, '1);
    send_request(REQ_PIXEL, rand_pixel());
    drain_stream();

    // random phases; the widest line runs only once and without noise
    run_phase(32'hFFFF_E005, 32'd4, 32'd7, 50, 4, -1);
    run_phase(32'd1, 32'd3, 32'hFFFF_FFF4, 40, 3, -1);
    run_phase(32'd17, 32'd5, 32'd0, 70, 3, 35);
    run_phase(32'd8, 32'd0, 32'hF, 50, 5, -1);
    run_phase(32'd6, 32'h1FFF, 32'd7, 40, 4, -1);
    run_phase(32'd32, 32'd3, 32'd4, 50, 0, -1);
    run_phase(32'd3, 32'd3, 32'hF, 50, 2, -1);
    settle();

    $display("Sent %0d pixel and %0d flush requests over %0d register settings,",
             n_pixels, n_flushes, n_settings);
    $display("checked %0d filtered results with %0d mismatches.",
             checked_count, fail_count);
    if (fail_count == 0 && owed_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: median_3x3_pixel_filter.f
hdl/mf3_pkg.sv
hdl/mf3_ram.sv
hdl/mf3_window_median.sv
hdl/median_3x3_pixel_filter.sv
verif/mf3_checker.sv
verif/tb.sv
